// ----- hdl/cst_pkg.sv -----
// Shared types, token and error codes and keyword lookup for the C subset tokenizer.
// No dependencies; used by c_subset_tokenizer_unit and cst_checker.
package cst_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] ch;
        logic       final_req;
    } in_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [3:0]  token_length;
        logic [31:0] text_prefix;
        logic [7:0]  literal_char;
        logic        literal_escaped;
        logic [2:0]  error_code;
        logic [15:0] row;
        logic [15:0] col;
        logic        last;
    } out_t;

    typedef enum logic [9:0] {
        MODE_IDLE   = 10'b00_0000_0001,
        MODE_NUM    = 10'b00_0000_0010,
        MODE_ID     = 10'b00_0000_0100,
        MODE_GT     = 10'b00_0000_1000,
        MODE_LT     = 10'b00_0001_0000,
        MODE_EQ     = 10'b00_0010_0000,
        MODE_BANG   = 10'b00_0100_0000,
        MODE_Q1     = 10'b00_1000_0000,
        MODE_QESC   = 10'b01_0000_0000,
        MODE_QCLOSE = 10'b10_0000_0000
    } mode_t;

    localparam logic [4:0] TK_MAIN     = 5'd0;
    localparam logic [4:0] TK_INT      = 5'd1;
    localparam logic [4:0] TK_CHAR     = 5'd2;
    localparam logic [4:0] TK_ID       = 5'd3;
    localparam logic [4:0] TK_NUM      = 5'd4;
    localparam logic [4:0] TK_LPAREN   = 5'd5;
    localparam logic [4:0] TK_RPAREN   = 5'd6;
    localparam logic [4:0] TK_LBRACE   = 5'd7;
    localparam logic [4:0] TK_RBRACE   = 5'd8;
    localparam logic [4:0] TK_LBRACKET = 5'd9;
    localparam logic [4:0] TK_RBRACKET = 5'd10;
    localparam logic [4:0] TK_SEMI     = 5'd11;
    localparam logic [4:0] TK_COMMA    = 5'd12;
    localparam logic [4:0] TK_ASSIGN   = 5'd13;
    localparam logic [4:0] TK_IF       = 5'd14;
    localparam logic [4:0] TK_ELSE     = 5'd15;
    localparam logic [4:0] TK_RELOP    = 5'd16;
    localparam logic [4:0] TK_END      = 5'd17;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_INVALID  = 3'd1;
    localparam logic [2:0] ERR_BANG     = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_EMPTY    = 3'd4;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd5;

    function automatic logic [4:0] word_kind(input logic [31:0] pfx, input logic [3:0] len);
        logic [4:0] k;
        k = TK_ID;
        if (len == 4'd4 && pfx == 32'h6D61_696E) k = TK_MAIN;
        else if (len == 4'd3 && pfx == 32'h696E_7400) k = TK_INT;
        else if (len == 4'd4 && pfx == 32'h6368_6172) k = TK_CHAR;
        else if (len == 4'd2 && pfx == 32'h6966_0000) k = TK_IF;
        else if (len == 4'd4 && pfx == 32'h656C_7365) k = TK_ELSE;
        return k;
    endfunction

    function automatic out_t mk_res(input logic [4:0] kind, input logic [3:0] len,
                                    input logic [31:0] pfx, input logic [7:0] lch,
                                    input logic esc, input logic [2:0] err,
                                    input logic [15:0] row, input logic [15:0] col);
        out_t r;
        r.token_kind      = kind;
        r.token_length    = len;
        r.text_prefix     = pfx;
        r.literal_char    = lch;
        r.literal_escaped = esc;
        r.error_code      = err;
        r.row             = row;
        r.col             = col;
        r.last            = 1'b0;
        return r;
    endfunction

endpackage

// ----- hdl/c_subset_tokenizer_unit.sv -----
// C subset tokenizer: one source byte per transfer in, tokens out through a small result queue.
// Each result is registered into the queue when its byte is accepted and is shown on m_data
// once the results ahead of it are taken. One byte per cycle while s_ready is high; a byte can
// yield two results; s_ready drops while more than two results wait in the four-entry queue.
// Reset: aresetn, synchronous active low, clears lexer state, position (1,1) and the queue.
// Depends on cst_pkg.
module c_subset_tokenizer_unit #(
    parameter int POS_BITS = cst_pkg::POS_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cst_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cst_pkg::out_t m_data
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    cst_pkg::mode_t mode_reg, mode_next;
    logic [31:0]         prefix_reg, prefix_next;
    logic [3:0]          count_reg, count_next;
    logic [7:0]          lit_reg, lit_next;
    logic                esc_reg, esc_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic                halted_reg, halted_next;
    logic                en_reg;

    cst_pkg::out_t               fifo_reg [cst_pkg::FIFO_DEPTH];
    logic [cst_pkg::PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [cst_pkg::CNT_W-1:0]   cnt_reg;

    logic          accept, pop;
    cst_pkg::out_t res_a, res_b, res0, res1;
    logic          a_v, b_v;
    logic [1:0]    n_res, push_n;
    logic [15:0]   row_o, col_o;
    logic [31:0]   line_w, col_w;
    logic [7:0]    c;
    logic          c_digit, c_alpha, c_space, c_eq;
    logic [31:0]   pfx_add;

    assign accept  = s_valid & s_ready;
    assign pop     = m_valid & m_ready;
    assign s_ready = en_reg && (cnt_reg <= cst_pkg::CNT_W'(cst_pkg::FIFO_DEPTH - 2));
    assign m_valid = (cnt_reg != '0);
    assign m_data  = fifo_reg[rd_ptr_reg];

    assign line_w = 32'(line_reg);
    assign col_w  = 32'(col_reg);
    assign row_o  = (line_w > 32'h0000_FFFF) ? 16'hFFFF : line_w[15:0];
    assign col_o  = (col_w > 32'h0000_FFFF) ? 16'hFFFF : col_w[15:0];

    assign c       = s_data.ch;
    assign c_digit = (c >= 8'h30) && (c <= 8'h39);
    assign c_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign c_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign c_eq    = (c == 8'h3D);

    always_comb begin
        case (count_reg)
            4'd1:    pfx_add = {prefix_reg[31:24], c, prefix_reg[15:0]};
            4'd2:    pfx_add = {prefix_reg[31:16], c, prefix_reg[7:0]};
            4'd3:    pfx_add = {prefix_reg[31:8], c};
            default: pfx_add = prefix_reg;
        endcase
    end

    always_comb begin
        logic done;
        logic failed;
        logic [4:0] wk;
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        count_next  = count_reg;
        lit_next    = lit_reg;
        esc_next    = esc_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        halted_next = halted_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        res_a       = '0;
        res_b       = '0;
        done        = 1'b0;
        failed      = 1'b0;
        wk          = cst_pkg::word_kind(prefix_reg, count_reg);

        if (!halted_reg) begin
            if (s_data.final_req) begin
                a_v = 1'b1;
                case (mode_reg)
                    cst_pkg::MODE_NUM:
                        res_a = cst_pkg::mk_res(cst_pkg::TK_NUM, count_reg, prefix_reg,
                                                8'h00, 1'b0, cst_pkg::ERR_NONE, row_o, col_o);
                    cst_pkg::MODE_ID:
                        res_a = cst_pkg::mk_res(wk, count_reg, prefix_reg,
                                                8'h00, 1'b0, cst_pkg::ERR_NONE, row_o, col_o);
                    cst_pkg::MODE_GT, cst_pkg::MODE_LT:
                        res_a = cst_pkg::mk_res(cst_pkg::TK_RELOP, 4'd0, 32'd0,
                                                8'h00, 1'b0, cst_pkg::ERR_NONE, row_o, col_o);
                    cst_pkg::MODE_EQ:
                        res_a = cst_pkg::mk_res(cst_pkg::TK_ASSIGN, 4'd0, 32'd0,
                                                8'h00, 1'b0, cst_pkg::ERR_NONE, row_o, col_o);
                    cst_pkg::MODE_BANG: begin
                        failed = 1'b1;
                        res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00, 1'b0,
                                                 cst_pkg::ERR_BANG, row_o, col_o);
                    end
                    cst_pkg::MODE_Q1: begin
                        failed = 1'b1;
                        res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00, 1'b0,
                                                 cst_pkg::ERR_EMPTY, row_o, col_o);
                    end
                    cst_pkg::MODE_QESC: begin
                        failed = 1'b1;
                        res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00, 1'b0,
                                                 cst_pkg::ERR_ESCAPE, row_o, col_o);
                    end
                    cst_pkg::MODE_QCLOSE: begin
                        failed = 1'b1;
                        res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00, 1'b0,
                                                 cst_pkg::ERR_NO_QUOTE, row_o, col_o);
                    end
                    default: a_v = 1'b0;
                endcase
                if (!failed) begin
                    b_v   = 1'b1;
                    res_b = cst_pkg::mk_res(cst_pkg::TK_END, 4'd0, 32'd0, 8'h00, 1'b0,
                                            cst_pkg::ERR_NONE, row_o, col_o);
                end
                mode_next = cst_pkg::MODE_IDLE;
            end else begin
                case (mode_reg)
                    cst_pkg::MODE_NUM: begin
                        if (c_digit) begin
                            done        = 1'b1;
                            prefix_next = (count_reg < 4'd4) ? pfx_add : prefix_reg;
                            count_next  = (count_reg < 4'd15) ? count_reg + 4'd1 : count_reg;
                        end else begin
                            a_v       = 1'b1;
                            res_a     = cst_pkg::mk_res(cst_pkg::TK_NUM, count_reg, prefix_reg,
                                                        8'h00, 1'b0, cst_pkg::ERR_NONE,
                                                        row_o, col_o);
                            mode_next = cst_pkg::MODE_IDLE;
                        end
                    end
                    cst_pkg::MODE_ID: begin
                        if (c_digit || c_alpha) begin
                            done        = 1'b1;
                            prefix_next = (count_reg < 4'd4) ? pfx_add : prefix_reg;
                            count_next  = (count_reg < 4'd15) ? count_reg + 4'd1 : count_reg;
                        end else begin
                            a_v       = 1'b1;
                            res_a     = cst_pkg::mk_res(wk, count_reg, prefix_reg, 8'h00, 1'b0,
                                                        cst_pkg::ERR_NONE, row_o, col_o);
                            mode_next = cst_pkg::MODE_IDLE;
                        end
                    end
                    cst_pkg::MODE_GT, cst_pkg::MODE_LT, cst_pkg::MODE_EQ: begin
                        a_v       = 1'b1;
                        done      = c_eq;
                        res_a     = cst_pkg::mk_res(
                            (c_eq || mode_reg != cst_pkg::MODE_EQ) ?
                                cst_pkg::TK_RELOP : cst_pkg::TK_ASSIGN,
                            4'd0, 32'd0, 8'h00, 1'b0, cst_pkg::ERR_NONE, row_o, col_o);
                        mode_next = cst_pkg::MODE_IDLE;
                    end
                    cst_pkg::MODE_BANG: begin
                        a_v       = 1'b1;
                        mode_next = cst_pkg::MODE_IDLE;
                        if (c_eq) begin
                            done  = 1'b1;
                            res_a = cst_pkg::mk_res(cst_pkg::TK_RELOP, 4'd0, 32'd0, 8'h00,
                                                    1'b0, cst_pkg::ERR_NONE, row_o, col_o);
                        end else begin
                            failed = 1'b1;
                            res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00,
                                                     1'b0, cst_pkg::ERR_BANG, row_o, col_o);
                        end
                    end
                    cst_pkg::MODE_Q1: begin
                        done = 1'b1;
                        if (c == 8'h5C) begin
                            mode_next = cst_pkg::MODE_QESC;
                        end else if (c == 8'h27) begin
                            a_v    = 1'b1;
                            failed = 1'b1;
                            res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00,
                                                     1'b0, cst_pkg::ERR_EMPTY, row_o, col_o);
                        end else begin
                            lit_next  = c;
                            esc_next  = 1'b0;
                            mode_next = cst_pkg::MODE_QCLOSE;
                        end
                    end
                    cst_pkg::MODE_QESC: begin
                        done = 1'b1;
                        if (c == 8'h6E || c == 8'h74 || c == 8'h72 || c == 8'h5C ||
                            c == 8'h27 || c == 8'h22) begin
                            lit_next  = c;
                            esc_next  = 1'b1;
                            mode_next = cst_pkg::MODE_QCLOSE;
                        end else begin
                            a_v    = 1'b1;
                            failed = 1'b1;
                            res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00,
                                                     1'b0, cst_pkg::ERR_ESCAPE, row_o, col_o);
                        end
                    end
                    cst_pkg::MODE_QCLOSE: begin
                        done = 1'b1;
                        a_v  = 1'b1;
                        if (c == 8'h27) begin
                            res_a     = cst_pkg::mk_res(cst_pkg::TK_NUM, 4'd0, 32'd0, lit_reg,
                                                        esc_reg, cst_pkg::ERR_NONE,
                                                        row_o, col_o);
                            mode_next = cst_pkg::MODE_IDLE;
                        end else begin
                            failed = 1'b1;
                            res_a  = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00,
                                                     1'b0, cst_pkg::ERR_NO_QUOTE, row_o, col_o);
                        end
                    end
                    default: mode_next = cst_pkg::MODE_IDLE;
                endcase

                // start of a new token
                if (!done && !failed && !c_space) begin
                    if (c_digit || c_alpha) begin
                        prefix_next = {c, 24'd0};
                        count_next  = 4'd1;
                        mode_next   = c_digit ? cst_pkg::MODE_NUM : cst_pkg::MODE_ID;
                    end else begin
                        b_v   = 1'b1;
                        res_b = cst_pkg::mk_res(cst_pkg::TK_MAIN, 4'd0, 32'd0, 8'h00, 1'b0,
                                                cst_pkg::ERR_NONE, row_o, col_o);
                        case (c)
                            8'h28: res_b.token_kind = cst_pkg::TK_LPAREN;
                            8'h29: res_b.token_kind = cst_pkg::TK_RPAREN;
                            8'h7B: res_b.token_kind = cst_pkg::TK_LBRACE;
                            8'h7D: res_b.token_kind = cst_pkg::TK_RBRACE;
                            8'h5B: res_b.token_kind = cst_pkg::TK_LBRACKET;
                            8'h5D: res_b.token_kind = cst_pkg::TK_RBRACKET;
                            8'h3B: res_b.token_kind = cst_pkg::TK_SEMI;
                            8'h2C: res_b.token_kind = cst_pkg::TK_COMMA;
                            8'h3E: begin
                                b_v       = 1'b0;
                                mode_next = cst_pkg::MODE_GT;
                            end
                            8'h3C: begin
                                b_v       = 1'b0;
                                mode_next = cst_pkg::MODE_LT;
                            end
                            8'h3D: begin
                                b_v       = 1'b0;
                                mode_next = cst_pkg::MODE_EQ;
                            end
                            8'h21: begin
                                b_v       = 1'b0;
                                mode_next = cst_pkg::MODE_BANG;
                            end
                            8'h27: begin
                                b_v       = 1'b0;
                                lit_next  = 8'h00;
                                esc_next  = 1'b0;
                                mode_next = cst_pkg::MODE_Q1;
                            end
                            default: begin
                                failed           = 1'b1;
                                res_b.error_code = cst_pkg::ERR_INVALID;
                            end
                        endcase
                    end
                end

                if (c == 8'h0A) begin
                    line_next = (line_reg != POS_MAX) ? line_reg + POS_BITS'(1) : line_reg;
                    col_next  = POS_BITS'(1);
                end else begin
                    col_next = (col_reg != POS_MAX) ? col_reg + POS_BITS'(1) : col_reg;
                end
            end
            if (failed) begin
                halted_next = 1'b1;
                mode_next   = cst_pkg::MODE_IDLE;
            end
        end

        res0      = a_v ? res_a : res_b;
        res1      = res_b;
        res0.last = !(a_v && b_v);
        res1.last = 1'b1;
        n_res     = {1'b0, a_v} + {1'b0, b_v};
    end

    assign push_n = accept ? n_res : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= cst_pkg::MODE_IDLE;
            prefix_reg <= '0;
            count_reg  <= '0;
            lit_reg    <= '0;
            esc_reg    <= 1'b0;
            line_reg   <= POS_BITS'(1);
            col_reg    <= POS_BITS'(1);
            halted_reg <= 1'b0;
            en_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            en_reg <= 1'b1;
            if (accept) begin
                mode_reg   <= mode_next;
                prefix_reg <= prefix_next;
                count_reg  <= count_next;
                lit_reg    <= lit_next;
                esc_reg    <= esc_next;
                line_reg   <= line_next;
                col_reg    <= col_next;
                halted_reg <= halted_next;
            end
            wr_ptr_reg <= wr_ptr_reg + cst_pkg::PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + cst_pkg::PTR_W'(pop);
            cnt_reg    <= cnt_reg + cst_pkg::CNT_W'(push_n) - cst_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            fifo_reg[wr_ptr_reg + cst_pkg::PTR_W'(1)] <= res1;
        end
    end

endmodule

// ----- hdl/cst_checker.sv -----
// Port-level checks for c_subset_tokenizer_unit, attached by the bind below.
// Depends on cst_pkg.
module cst_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input cst_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input cst_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity straight after reset");

    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.row != 16'd0 && m_data.col != 16'd0)
        else $error("position reads zero");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.token_kind <= cst_pkg::TK_END)
        else $error("token kind out of range");

    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != cst_pkg::ERR_NONE |->
            m_data.token_kind == cst_pkg::TK_MAIN && m_data.last)
        else $error("malformed error result");

endmodule

bind c_subset_tokenizer_unit cst_checker u_cst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
